[hw/rtl/ipv4_receive_header_check_assert.svh]
// Assertion macros shared by the IPv4 receive header check RTL.
`ifndef IPV4_RECEIVE_HEADER_CHECK_ASSERT_SVH
`define IPV4_RECEIVE_HEADER_CHECK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPV4HC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipv4 header check: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define IPV4HC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipv4 header check: next-cycle property failed");

`endif

[hw/rtl/ipv4hc_pkg.sv]
// Types and constants of the IPv4 receive header check.
package ipv4hc_pkg;

  localparam logic [3:0] VERDICT_DELIVER    = 4'd0;
  localparam logic [3:0] VERDICT_FRAGMENT   = 4'd1;
  localparam logic [3:0] VERDICT_PROTO_UNRCH = 4'd2;
  localparam logic [3:0] VERDICT_SHORT      = 4'd3;
  localparam logic [3:0] VERDICT_VERSION    = 4'd4;
  localparam logic [3:0] VERDICT_HDRLEN     = 4'd5;
  localparam logic [3:0] VERDICT_TOTALLEN   = 4'd6;
  localparam logic [3:0] VERDICT_CHECKSUM   = 4'd7;
  localparam logic [3:0] VERDICT_WRONG_DST  = 4'd8;

  localparam logic [15:0] HDR_MIN_BYTES = 16'd20;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam int          OFFSET_SHIFT  = 3;
  localparam int          MF_BIT        = 13;
  localparam logic [15:0] CNT_MAX       = 16'hFFFF;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Header byte positions.
  localparam logic [15:0] POS_VIHL     = 16'd0;
  localparam logic [15:0] POS_TOT_HI   = 16'd2;
  localparam logic [15:0] POS_TOT_LO   = 16'd3;
  localparam logic [15:0] POS_ID_HI    = 16'd4;
  localparam logic [15:0] POS_ID_LO    = 16'd5;
  localparam logic [15:0] POS_FLAGS_HI = 16'd6;
  localparam logic [15:0] POS_FLAGS_LO = 16'd7;
  localparam logic [15:0] POS_PROTO    = 16'd9;
  localparam logic [15:0] POS_CSUM_HI  = 16'd10;
  localparam logic [15:0] POS_CSUM_LO  = 16'd11;
  localparam logic [15:0] POS_SRC_0    = 16'd12;
  localparam logic [15:0] POS_SRC_1    = 16'd13;
  localparam logic [15:0] POS_SRC_2    = 16'd14;
  localparam logic [15:0] POS_SRC_3    = 16'd15;
  localparam logic [15:0] POS_DST_0    = 16'd16;
  localparam logic [15:0] POS_DST_1    = 16'd17;
  localparam logic [15:0] POS_DST_2    = 16'd18;
  localparam logic [15:0] POS_DST_3    = 16'd19;

  // Frame state as it stands after the current byte.
  typedef struct packed {
    logic [15:0] frame_len;
    logic [7:0]  vihl;
    logic [15:0] tot_length;
    logic [15:0] ident;
    logic [15:0] flags_offset;
    logic [7:0]  proto;
    logic [15:0] rx_csum;
    logic [31:0] src;
    logic [31:0] dst;
    logic [16:0] sum;
  } frame_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [15:0] packet_id;
    logic [15:0] fragment_byte_offset;
    logic        more_fragments;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;
  } result_t;

endpackage

[hw/rtl/ipv4hc_ifs.sv]
// Channel interfaces of the IPv4 receive header check.
interface ipv4hc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ipv4hc_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [15:0] packet_id;
  logic [15:0] fragment_byte_offset;
  logic        more_fragments;
  logic [5:0]  header_bytes;
  logic [15:0] payload_bytes;
  modport source (output valid, verdict, protocol_number, source_address, packet_id,
                  fragment_byte_offset, more_fragments, header_bytes, payload_bytes,
                  input ready);
  modport sink (input valid, verdict, protocol_number, source_address, packet_id,
                fragment_byte_offset, more_fragments, header_bytes, payload_bytes,
                output ready);
endinterface

interface ipv4hc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] local_ip_address;
  modport source (output valid, local_ip_address, input ready);
  modport sink (input valid, local_ip_address, output ready);
endinterface

[hw/rtl/ipv4hc_capture.sv]
// Per-frame state: byte count, header field capture and running checksum.
module ipv4hc_capture
  import ipv4hc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output frame_t     nxt
);

  logic [15:0] byte_cnt;
  logic [7:0]  vihl;
  logic [15:0] tot_length;
  logic [15:0] ident;
  logic [15:0] flags_offset;
  logic [7:0]  proto;
  logic [15:0] rx_csum;
  logic [31:0] src;
  logic [31:0] dst;
  logic [16:0] sum;
  logic [7:0]  hold;

  logic [7:0]  hold_next;
  logic [5:0]  hdr_next;
  logic [7:0]  word_lo;
  logic [17:0] sum_raw;

  always_comb begin
    nxt.vihl         = vihl;
    nxt.tot_length   = tot_length;
    nxt.ident        = ident;
    nxt.flags_offset = flags_offset;
    nxt.proto        = proto;
    nxt.rx_csum      = rx_csum;
    nxt.src          = src;
    nxt.dst          = dst;
    unique case (byte_cnt)
      POS_VIHL: nxt.vihl = data_byte;
      POS_TOT_HI, POS_TOT_LO: nxt.tot_length = {tot_length[7:0], data_byte};
      POS_ID_HI, POS_ID_LO: nxt.ident = {ident[7:0], data_byte};
      POS_FLAGS_HI, POS_FLAGS_LO: nxt.flags_offset = {flags_offset[7:0], data_byte};
      POS_PROTO: nxt.proto = data_byte;
      POS_CSUM_HI, POS_CSUM_LO: nxt.rx_csum = {rx_csum[7:0], data_byte};
      POS_SRC_0, POS_SRC_1, POS_SRC_2, POS_SRC_3: nxt.src = {src[23:0], data_byte};
      POS_DST_0, POS_DST_1, POS_DST_2, POS_DST_3: nxt.dst = {dst[23:0], data_byte};
      default: ;
    endcase

    // Header length uses the IHL of this very byte when it is the first one.
    hdr_next = {nxt.vihl[3:0], 2'b00};
    // Checksum field counts as zero.
    word_lo  = (byte_cnt == POS_CSUM_HI || byte_cnt == POS_CSUM_LO) ? 8'd0 : data_byte;
    sum_raw  = {1'b0, sum} + {2'b00, hold, word_lo};
    nxt.sum  = sum;
    hold_next = hold;
    if (byte_cnt < {10'd0, hdr_next}) begin
      if (!byte_cnt[0]) begin
        hold_next = word_lo;
      end else begin
        nxt.sum = {1'b0, sum_raw[15:0]} + {15'd0, sum_raw[17:16]};
      end
    end
    nxt.frame_len = (byte_cnt == CNT_MAX) ? byte_cnt : byte_cnt + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_cnt     <= '0;
      vihl         <= '0;
      tot_length   <= '0;
      ident        <= '0;
      flags_offset <= '0;
      proto        <= '0;
      rx_csum      <= '0;
      src          <= '0;
      dst          <= '0;
      sum          <= '0;
      hold         <= '0;
    end else if (step) begin
      byte_cnt     <= nxt.frame_len;
      vihl         <= nxt.vihl;
      tot_length   <= nxt.tot_length;
      ident        <= nxt.ident;
      flags_offset <= nxt.flags_offset;
      proto        <= nxt.proto;
      rx_csum      <= nxt.rx_csum;
      src          <= nxt.src;
      dst          <= nxt.dst;
      sum          <= nxt.sum;
      hold         <= hold_next;
    end
  end

endmodule

[hw/rtl/ipv4hc_judge.sv]
// Verdict and result fields for a completed frame.
module ipv4hc_judge
  import ipv4hc_pkg::*;
(
  input  frame_t      frm,
  input  logic [31:0] local_ip,
  output result_t     res
);

  logic [5:0]  hdr;
  logic [15:0] hdr_w;
  logic [15:0] computed;
  logic [15:0] offs;
  logic        mf;
  logic        proto_ok;
  logic [3:0]  verdict;

  always_comb begin
    hdr      = {frm.vihl[3:0], 2'b00};
    hdr_w    = {10'd0, hdr};
    computed = ~frm.sum[15:0];
    mf       = frm.flags_offset[MF_BIT];
    offs     = {frm.flags_offset[12:0], 3'b000} << (OFFSET_SHIFT - 3);
    proto_ok = (frm.proto == PROTO_ICMP) || (frm.proto == PROTO_TCP) ||
               (frm.proto == PROTO_UDP);

    priority if (frm.frame_len < HDR_MIN_BYTES) begin
      verdict = VERDICT_SHORT;
    end else if (frm.vihl[7:4] != IP_VERSION) begin
      verdict = VERDICT_VERSION;
    end else if (hdr_w < HDR_MIN_BYTES || hdr_w > frm.frame_len) begin
      verdict = VERDICT_HDRLEN;
    end else if (frm.tot_length > frm.frame_len || frm.tot_length < hdr_w) begin
      verdict = VERDICT_TOTALLEN;
    end else if (computed != frm.rx_csum) begin
      verdict = VERDICT_CHECKSUM;
    end else if (frm.dst != local_ip) begin
      verdict = VERDICT_WRONG_DST;
    end else if (!proto_ok) begin
      verdict = VERDICT_PROTO_UNRCH;
    end else if (mf || offs != 16'd0) begin
      verdict = VERDICT_FRAGMENT;
    end else begin
      verdict = VERDICT_DELIVER;
    end

    res.verdict              = verdict;
    res.protocol_number      = frm.proto;
    res.source_address       = frm.src;
    res.packet_id            = frm.ident;
    res.fragment_byte_offset = offs;
    res.more_fragments       = mf;
    res.header_bytes         = hdr;
    res.payload_bytes        = (verdict <= VERDICT_PROTO_UNRCH) ? frm.tot_length - hdr_w
                                                                : 16'd0;
  end

endmodule

[hw/rtl/ipv4_receive_header_check.sv]
// IPv4 receive header check: one byte per clock in, one verdict per frame out.
// Accepts one packet byte every clock cycle unless stalled by a waiting result,
// with no gaps between frames. Each byte is held in an input register, then
// updates the frame state (field capture and a ones' complement checksum folded
// once per 16-bit word). On the byte marked last, the verdict and header fields
// are formed from that state and loaded into the result register, so res.valid
// rises in the cycle after the last byte leaves the input register. A waiting
// result stalls input only when the next frame's last byte needs the result
// register. The local address is written through the configuration channel,
// which is always ready.
module ipv4_receive_header_check
  import ipv4hc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  ipv4hc_byte_if.sink      pkt,
  ipv4hc_result_if.source  res,
  ipv4hc_cfg_if.sink       cfg
);

  logic [31:0] local_ip;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_adv;

  frame_t      frm_next;
  result_t     judged;
  result_t     res_q;
  logic        res_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= '0;
    end else if (cfg.valid) begin
      local_ip <= cfg.local_ip_address;
    end
  end

  // A last byte advances only when the result register can take its result.
  assign s1_adv    = s1_valid && (!s1_last || !res_valid || res.ready);
  assign pkt.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt.ready) begin
      s1_valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.ready && pkt.valid) begin
      s1_byte <= pkt.data_byte;
      s1_last <= pkt.last_byte;
    end
  end

  ipv4hc_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .nxt       (frm_next)
  );

  ipv4hc_judge u_judge (
    .frm      (frm_next),
    .local_ip (local_ip),
    .res      (judged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      res_q <= judged;
    end
  end

  assign res.valid                = res_valid;
  assign res.verdict              = res_q.verdict;
  assign res.protocol_number      = res_q.protocol_number;
  assign res.source_address       = res_q.source_address;
  assign res.packet_id            = res_q.packet_id;
  assign res.fragment_byte_offset = res_q.fragment_byte_offset;
  assign res.more_fragments       = res_q.more_fragments;
  assign res.header_bytes         = res_q.header_bytes;
  assign res.payload_bytes        = res_q.payload_bytes;

`include "ipv4_receive_header_check_assert.svh"

  `IPV4HC_ASSERT_NEXT(a_last_gives_result, s1_adv && s1_last, res_valid)
  `IPV4HC_ASSERT_SAME(a_reject_no_payload,
                      res_valid && res_q.verdict >= VERDICT_SHORT,
                      res_q.payload_bytes == 16'd0)
  `IPV4HC_ASSERT_SAME(a_deliver_unfragmented,
                      res_valid && res_q.verdict == VERDICT_DELIVER,
                      !res_q.more_fragments && res_q.fragment_byte_offset == 16'd0)

endmodule
